// ===== hw/rtl/dlrr_pkg.sv =====
// shared types and constants of the diagnostic link request/response block
package dlrr_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RX    = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_ECHO   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TIMEOUT = 2'd1,
    STAT_CHKERR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_REQ,
    JOB_ECHO,
    JOB_ECHO_FINAL,
    JOB_TIMEOUT
  } job_e;

  localparam logic [15:0] TimeoutReset = 16'd30;
  localparam logic [9:0]  TimeoutWrap  = 10'd1000;
  localparam logic [8:0]  ReplyExtra   = 9'd3;
  localparam int unsigned ReqBytes     = 5;

  // one unit of work handed from the front to the back
  typedef struct packed {
    job_e             kind;
    logic [4:0][7:0]  bytes;
    logic [8:0]       pos;
    status_e          status;
    logic [9:0]       tcount;
  } job_t;

  // 0xff - (sum - 1) modulo 256
  function automatic logic [7:0] frame_check(logic [7:0] sum);
    frame_check = 8'hff - (sum - 8'h01);
  endfunction

endpackage

// ===== hw/rtl/dlrr_front.sv =====
// front part: accepts items, tracks the exchange state and issues jobs
module dlrr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           header_byte_i,
  input  logic [7:0]           count_sent_i,
  input  logic [7:0]           address_i,
  input  logic [7:0]           read_length_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 job_push_o,
  output dlrr_pkg::job_t       job_o
);

  logic [15:0] timeout_ticks_q;
  logic        waiting_q, waiting_d;
  logic [8:0]  bytes_received_q, bytes_received_d;
  logic [8:0]  expected_total_q, expected_total_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [15:0] ticks_left_q, ticks_left_d;
  logic [9:0]  timeout_count_q, timeout_count_d;

  logic [7:0]  req_sum;
  logic [9:0]  pos_next;

  always_comb begin
    waiting_d        = waiting_q;
    bytes_received_d = bytes_received_q;
    expected_total_d = expected_total_q;
    running_sum_d    = running_sum_q;
    ticks_left_d     = ticks_left_q;
    timeout_count_d  = timeout_count_q;
    job_push_o       = 1'b0;
    req_sum          = header_byte_i + count_sent_i + address_i + read_length_i;
    pos_next         = {1'b0, bytes_received_q} + 10'd1;

    job_o.kind   = dlrr_pkg::JOB_REQ;
    job_o.bytes  = {dlrr_pkg::frame_check(req_sum), read_length_i, address_i,
                    count_sent_i, header_byte_i};
    job_o.pos    = bytes_received_q;
    job_o.status = dlrr_pkg::STAT_OK;
    job_o.tcount = timeout_count_q;

    if (accept_i) begin
      case (dlrr_pkg::cmd_e'(cmd_i))
        dlrr_pkg::CMD_START: begin
          waiting_d        = 1'b1;
          bytes_received_d = '0;
          expected_total_d = {1'b0, read_length_i} + dlrr_pkg::ReplyExtra;
          running_sum_d    = '0;
          ticks_left_d     = timeout_ticks_q;
          job_push_o       = 1'b1;
        end
        dlrr_pkg::CMD_RX: begin
          if (waiting_q) begin
            job_push_o       = 1'b1;
            job_o.bytes      = {32'd0, rx_byte_i};
            bytes_received_d = pos_next[8:0];
            if (pos_next < {1'b0, expected_total_q}) begin
              running_sum_d = running_sum_q + rx_byte_i;
              job_o.kind    = dlrr_pkg::JOB_ECHO;
            end else begin
              waiting_d     = 1'b0;
              job_o.kind    = dlrr_pkg::JOB_ECHO_FINAL;
              job_o.status  = (dlrr_pkg::frame_check(running_sum_q) == rx_byte_i)
                              ? dlrr_pkg::STAT_OK : dlrr_pkg::STAT_CHKERR;
            end
          end
        end
        dlrr_pkg::CMD_TICK: begin
          if (waiting_q) begin
            if (ticks_left_q > 16'd1) begin
              ticks_left_d = ticks_left_q - 16'd1;
            end else begin
              ticks_left_d    = '0;
              waiting_d       = 1'b0;
              timeout_count_d = (timeout_count_q >= dlrr_pkg::TimeoutWrap)
                                ? '0 : timeout_count_q + 10'd1;
              job_push_o      = 1'b1;
              job_o.kind      = dlrr_pkg::JOB_TIMEOUT;
              job_o.status    = dlrr_pkg::STAT_TIMEOUT;
              job_o.tcount    = timeout_count_d;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q  <= dlrr_pkg::TimeoutReset;
      waiting_q        <= 1'b0;
      bytes_received_q <= '0;
      expected_total_q <= '0;
      running_sum_q    <= '0;
      ticks_left_q     <= '0;
      timeout_count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_ticks_q <= cfg_wdata_i;
      end
      waiting_q        <= waiting_d;
      bytes_received_q <= bytes_received_d;
      expected_total_q <= expected_total_d;
      running_sum_q    <= running_sum_d;
      ticks_left_q     <= ticks_left_d;
      timeout_count_q  <= timeout_count_d;
    end
  end

endmodule

// ===== hw/rtl/dlrr_fifo.sv =====
// short job queue between the front and the back
module dlrr_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dlrr_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dlrr_pkg::job_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dlrr_pkg::job_t mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dlrr_back.sv =====
// back part: expands each job into result items behind an output register
module dlrr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  dlrr_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     value_o,
  output logic [8:0]     position_o,
  output logic [1:0]     status_o,
  output logic           last_o,
  output logic [9:0]     timeouts_seen_o
);

  logic       out_valid_q, out_valid_d;
  logic [2:0] step_q, step_d;
  logic       advance, job_done;

  dlrr_pkg::kind_e   kind_d;
  dlrr_pkg::status_e status_d;
  logic [7:0]        value_d;
  logic [8:0]        position_d;
  logic              last_d;

  logic [1:0]        kind_q;
  logic [7:0]        value_q;
  logic [8:0]        position_q;
  logic [1:0]        status_q;
  logic              last_q;
  logic [9:0]        tcount_q;

  assign advance = !out_valid_q || pop_i;
  assign empty_o = !out_valid_q;

  assign kind_o          = kind_q;
  assign value_o         = value_q;
  assign position_o      = position_q;
  assign status_o        = status_q;
  assign last_o          = last_q;
  assign timeouts_seen_o = tcount_q;

  always_comb begin
    kind_d     = dlrr_pkg::KIND_TX;
    value_d    = '0;
    position_d = '0;
    status_d   = dlrr_pkg::STAT_OK;
    last_d     = 1'b1;
    job_done   = 1'b1;
    case (job_i.kind)
      dlrr_pkg::JOB_REQ: begin
        case (step_q)
          3'd0:    value_d = job_i.bytes[0];
          3'd1:    value_d = job_i.bytes[1];
          3'd2:    value_d = job_i.bytes[2];
          3'd3:    value_d = job_i.bytes[3];
          default: value_d = job_i.bytes[4];
        endcase
        position_d = 9'(step_q);
        job_done   = (step_q == 3'(dlrr_pkg::ReqBytes - 1));
        last_d     = job_done;
      end
      dlrr_pkg::JOB_ECHO: begin
        kind_d     = dlrr_pkg::KIND_ECHO;
        value_d    = job_i.bytes[0];
        position_d = job_i.pos;
      end
      dlrr_pkg::JOB_ECHO_FINAL: begin
        // echo first, then the checksum verdict
        if (step_q == 3'd0) begin
          kind_d     = dlrr_pkg::KIND_ECHO;
          value_d    = job_i.bytes[0];
          position_d = job_i.pos;
          last_d     = 1'b0;
          job_done   = 1'b0;
        end else begin
          kind_d   = dlrr_pkg::KIND_STATUS;
          status_d = job_i.status;
        end
      end
      default: begin
        kind_d   = dlrr_pkg::KIND_STATUS;
        status_d = job_i.status;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    step_d      = step_q;
    job_pop_o   = 1'b0;
    if (advance) begin
      out_valid_d = !job_empty_i;
      if (!job_empty_i) begin
        if (job_done) begin
          job_pop_o = 1'b1;
          step_d    = '0;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !job_empty_i) begin
      kind_q     <= kind_d;
      value_q    <= value_d;
      position_q <= position_d;
      status_q   <= status_d;
      last_q     <= last_d;
      tcount_q   <= job_i.tcount;
    end
  end

endmodule

// ===== hw/rtl/diag_link_request_response.sv =====
// Master side of a single-wire diagnostic request/response exchange. Items
// are accepted one per cycle while the job queue (QueueDepth entries) has
// room. With the queue and the output register empty, an item that yields a
// job passes through the job queue and then the output register before its
// first result is on the result ports. Results leave the output register at
// one per cycle while pop is asserted; a request yields 5 results, a final
// reply byte 2, and other items 1 or none, so the output register is what
// sets the sustained result rate.
module diag_link_request_response #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  header_byte_i,
  input  logic [7:0]  count_sent_i,
  input  logic [7:0]  address_i,
  input  logic [7:0]  read_length_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [8:0]  position_o,
  output logic [1:0]  status_o,
  output logic        last_o,
  output logic [9:0]  timeouts_seen_o
);

  dlrr_pkg::job_t front_job, head_job;
  logic           front_push, job_empty, job_pop;

  dlrr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (push && !full),
    .cmd_i         (cmd_i),
    .header_byte_i (header_byte_i),
    .count_sent_i  (count_sent_i),
    .address_i     (address_i),
    .read_length_i (read_length_i),
    .rx_byte_i     (rx_byte_i),
    .job_push_o    (front_push),
    .job_o         (front_job)
  );

  dlrr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (head_job)
  );

  dlrr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_empty_i     (job_empty),
    .job_i           (head_job),
    .job_pop_o       (job_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .position_o      (position_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .timeouts_seen_o (timeouts_seen_o)
  );

endmodule
